// ===== hdl/fcpa_pkg.sv =====
// shared widths, codes and controller/datapath structs of the chunk pool allocator
package fcpa_pkg;

    // field widths of the channels
    localparam int REQ_TYPE_W   = 2;
    localparam int FIELD_ADDR_W = 32;
    localparam int STATUS_W     = 3;
    localparam int CNUM_W       = 10;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    // geometry widths
    localparam int CSIZE_W = 16;
    localparam int ALIGN_W = 13;
    localparam int SIZE_W  = 17;

    // request types
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FREE     = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_FREE_ALL = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOB        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_ALIGNMENT = 8'd3;

    // configuration reset values
    localparam logic [CSIZE_W-1:0] CHUNK_SIZE_RST  = 16'd16;
    localparam logic [ALIGN_W-1:0] CHUNK_ALIGN_RST = 13'd8;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_IDX   = 2'd0,
        MUL_TOTAL = 2'd1,
        MUL_MAX   = 2'd2
    } mul_sel_t;

    // divider dividend select
    typedef enum logic {
        DIV_OFF = 1'b0,
        DIV_LEN = 1'b1
    } div_src_t;

    // result field source
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_ALLOC = 2'd1,
        RES_QUOT  = 2'd2
    } res_src_t;

    // controller to datapath commands
    typedef struct packed {
        logic                accept;
        logic                mul_en;
        mul_sel_t            mul_sel;
        logic                off_load;
        logic                div_start;
        div_src_t            div_src;
        logic                pop;
        logic                take_mark;
        logic                push;
        logic                total_max;
        logic                total_quot;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        res_src_t            res_src;
        logic                out_load;
    } fcpa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic                  is_null;
        logic                  head_valid;
        logic                  mark_avail;
        logic                  off_ge_region;
        logic                  len_ge_max;
        logic                  div_done;
        logic                  rem_nonzero;
        logic                  out_free;
    } fcpa_stat_t;

endpackage

// ===== hdl/fcpa_if.sv =====
// request, response and configuration channel interfaces

// request channel
interface fcpa_req_if;
    import fcpa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic                  addr_is_null;
    logic [FIELD_ADDR_W-1:0] free_addr;

    modport source (output valid, req_type, addr_is_null, free_addr, input ready);
    modport sink (input valid, req_type, addr_is_null, free_addr, output ready);
endinterface

// response channel
interface fcpa_rsp_if;
    import fcpa_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [FIELD_ADDR_W-1:0] chunk_addr;
    logic [CNUM_W-1:0]       chunk_number;

    modport source (output valid, status, chunk_addr, chunk_number, input ready);
    modport sink (input valid, status, chunk_addr, chunk_number, output ready);
endinterface

// configuration write channel
interface fcpa_cfg_if;
    import fcpa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fcpa_div.sv =====
// restoring divider, one quotient bit per cycle
module fcpa_div #(
    parameter int QW = 10,
    parameter int RW = 27
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [RW-1:0]              dividend,
    input  logic [fcpa_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [QW-1:0]              quotient,
    output logic [RW-1:0]              remainder
);
    import fcpa_pkg::*;

    localparam int CNT_W = $clog2(QW + 1);

    logic [RW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    dvs_reg, dvs_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fit;

    // one compare and subtract per step, divisor walks right
    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fit       = (rem_reg >= dvs_reg);
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = RW'(divisor) << (QW - 1);
            quo_next  = '0;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fit)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            quo_next = QW'({quo_reg, fit});
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done      = !busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/fcpa_dpath.sv =====
// datapath: configuration, geometry, free list, link memory, multiplier and result registers
module fcpa_dpath #(
    parameter int MAX_CHUNKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fcpa_pkg::REQ_TYPE_W-1:0]   req_type,
    input  logic                              addr_is_null,
    input  logic [fcpa_pkg::FIELD_ADDR_W-1:0] free_addr,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [fcpa_pkg::STATUS_W-1:0]     status,
    output logic [fcpa_pkg::FIELD_ADDR_W-1:0] chunk_addr,
    output logic [fcpa_pkg::CNUM_W-1:0]       chunk_number,
    input  fcpa_pkg::fcpa_cmd_t               cmd,
    output fcpa_pkg::fcpa_stat_t              stat
);
    import fcpa_pkg::*;

    localparam int QW    = $clog2(MAX_CHUNKS);
    localparam int IDX_W = $clog2(MAX_CHUNKS + 1);
    localparam int PW    = IDX_W + SIZE_W;
    localparam int RW    = SIZE_W + QW;
    localparam int CW    = (ADDR_BITS > PW) ? ADDR_BITS : PW;
    localparam int LW    = (FIELD_ADDR_W > PW) ? FIELD_ADDR_W : PW;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_CHUNKS);

    // configuration registers
    logic [FIELD_ADDR_W-1:0] base_cfg_reg;
    logic [FIELD_ADDR_W-1:0] len_cfg_reg;
    logic [CSIZE_W-1:0]      size_cfg_reg;
    logic [ALIGN_W-1:0]      align_cfg_reg;

    // geometry pipeline
    logic [ALIGN_W-1:0]      align_nz;
    logic [ALIGN_W-1:0]      align_lsb;
    logic [ALIGN_W-1:0]      amask_reg;
    logic [CSIZE_W-1:0]      size_nz_reg;
    logic [ALIGN_W-1:0]      adj;
    logic [ADDR_BITS-1:0]    base_al_reg;
    logic [FIELD_ADDR_W-1:0] len_cut_reg;
    logic [SIZE_W-1:0]       size_reg;

    // request fields
    logic [REQ_TYPE_W-1:0]   req_type_reg;
    logic                    null_reg;
    logic [ADDR_BITS-1:0]    addr_reg;

    // arithmetic
    logic [IDX_W-1:0]        mul_a;
    logic [PW-1:0]           product_reg;
    logic [ADDR_BITS-1:0]    off_reg;
    logic [ADDR_BITS-1:0]    alloc_addr;
    logic [RW-1:0]           dividend;
    logic                    div_done;
    logic [QW-1:0]           quot;
    logic [RW-1:0]           rem;

    // free list state
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        mark_reg, mark_next;
    logic [IDX_W-1:0]        total_reg, total_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    head_valid;
    logic [QW-1:0]           rd_addr;
    logic [IDX_W-1:0]        rd_reg;
    logic [IDX_W-1:0]        link_mem [MAX_CHUNKS];

    // result staging and output register
    logic [STATUS_W-1:0]     res_status_reg;
    logic [FIELD_ADDR_W-1:0] res_caddr_reg;
    logic [CNUM_W-1:0]       res_cnum_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [FIELD_ADDR_W-1:0] out_caddr_reg;
    logic [CNUM_W-1:0]       out_cnum_reg;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg  <= '0;
            len_cfg_reg   <= '0;
            size_cfg_reg  <= CHUNK_SIZE_RST;
            align_cfg_reg <= CHUNK_ALIGN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUFFER_BASE:     base_cfg_reg  <= cfg_data;
                CFG_BUFFER_LENGTH:   len_cfg_reg   <= cfg_data;
                CFG_CHUNK_SIZE:      size_cfg_reg  <= cfg_data[CSIZE_W-1:0];
                CFG_CHUNK_ALIGNMENT: align_cfg_reg <= cfg_data[ALIGN_W-1:0];
                default:             ;
            endcase
        end
    end

    // alignment reduced to its lowest set bit, zero counts as one
    assign align_nz  = (align_cfg_reg == '0) ? ALIGN_W'(1) : align_cfg_reg;
    assign align_lsb = align_nz & (~align_nz + ALIGN_W'(1));
    assign adj       = (~base_cfg_reg[ALIGN_W-1:0] + ALIGN_W'(1)) & amask_reg;

    // geometry registers: mask and non-zero size first, then aligned base, cut length and rounded size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amask_reg   <= CHUNK_ALIGN_RST - ALIGN_W'(1);
            size_nz_reg <= CHUNK_SIZE_RST;
            base_al_reg <= '0;
            len_cut_reg <= '0;
            size_reg    <= SIZE_W'(CHUNK_SIZE_RST);
        end
        else
        begin
            amask_reg   <= align_lsb - ALIGN_W'(1);
            size_nz_reg <= (size_cfg_reg == '0) ? CSIZE_W'(1) : size_cfg_reg;
            base_al_reg <= ADDR_BITS'(base_cfg_reg) + ADDR_BITS'(adj);
            len_cut_reg <= (len_cfg_reg >= FIELD_ADDR_W'(adj))
                           ? len_cfg_reg - FIELD_ADDR_W'(adj) : '0;
            size_reg    <= (SIZE_W'(size_nz_reg) + SIZE_W'(amask_reg)) & ~SIZE_W'(amask_reg);
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg <= req_type;
            null_reg     <= addr_is_null;
            addr_reg     <= ADDR_BITS'(free_addr);
        end
    end

    // shared multiplier operand
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_IDX:   mul_a = idx_reg;
            MUL_TOTAL: mul_a = total_reg;
            MUL_MAX:   mul_a = NULL_IDX;
            default:   mul_a = '0;
        endcase
    end

    // product and buffer offset
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            product_reg <= PW'(mul_a) * PW'(size_reg);
        end
        if (cmd.off_load)
        begin
            off_reg <= addr_reg - base_al_reg;
        end
    end

    assign alloc_addr = base_al_reg + ADDR_BITS'(product_reg);
    assign dividend   = (cmd.div_src == DIV_LEN) ? RW'(len_cut_reg) : RW'(off_reg);

    fcpa_div #(
        .QW (QW),
        .RW (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (size_reg),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    // free list head, unissued counter and chunk total
    assign head_valid = (head_reg != NULL_IDX);
    assign rd_addr    = head_valid ? head_reg[QW-1:0] : '0;

    always_comb
    begin
        head_next  = head_reg;
        mark_next  = mark_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        if (cmd.pop)
        begin
            idx_next  = head_reg;
            head_next = rd_reg;
        end
        if (cmd.take_mark)
        begin
            idx_next  = mark_reg;
            mark_next = mark_reg + IDX_W'(1);
        end
        if (cmd.push)
        begin
            head_next = IDX_W'(quot);
        end
        if (cmd.total_max || cmd.total_quot)
        begin
            total_next = cmd.total_max ? NULL_IDX : IDX_W'(quot);
            mark_next  = '0;
            head_next  = NULL_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NULL_IDX;
            mark_reg  <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            mark_reg  <= mark_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
        end
    end

    // link memory, read port follows the head
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[quot] <= head_reg;
        end
        rd_reg <= link_mem[rd_addr];
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_src)
                RES_ALLOC:
                begin
                    res_caddr_reg <= FIELD_ADDR_W'(alloc_addr);
                    res_cnum_reg  <= CNUM_W'(idx_reg);
                end
                RES_QUOT:
                begin
                    res_caddr_reg <= '0;
                    res_cnum_reg  <= CNUM_W'(quot);
                end
                default:
                begin
                    res_caddr_reg <= '0;
                    res_cnum_reg  <= '0;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_caddr_reg  <= res_caddr_reg;
            out_cnum_reg   <= res_cnum_reg;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign chunk_addr   = out_caddr_reg;
    assign chunk_number = out_cnum_reg;

    // status toward the controller
    always_comb
    begin
        stat.req_type      = req_type_reg;
        stat.is_null       = null_reg;
        stat.head_valid    = head_valid;
        stat.mark_avail    = (mark_reg < total_reg);
        stat.off_ge_region = (CW'(off_reg) >= CW'(product_reg));
        stat.len_ge_max    = (LW'(len_cut_reg) >= LW'(product_reg));
        stat.div_done      = div_done;
        stat.rem_nonzero   = (rem != '0);
        stat.out_free      = !out_valid_reg || rsp_ready;
    end

endmodule

// ===== hdl/fcpa_ctrl.sv =====
// controller state machine sequencing one request at a time
module fcpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output fcpa_pkg::fcpa_cmd_t  cmd,
    input  fcpa_pkg::fcpa_stat_t stat
);
    import fcpa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DISPATCH  = 12'b0000_0000_0010,
        S_ALLOC_MUL = 12'b0000_0000_0100,
        S_ALLOC_ADD = 12'b0000_0000_1000,
        S_FREE_MUL  = 12'b0000_0001_0000,
        S_FREE_CMP  = 12'b0000_0010_0000,
        S_FA_MUL    = 12'b0000_0100_0000,
        S_FA_CMP    = 12'b0000_1000_0000,
        S_DIV_WAIT  = 12'b0001_0000_0000,
        S_FREE_END  = 12'b0010_0000_0000,
        S_FA_END    = 12'b0100_0000_0000,
        S_LOAD      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_IDX;
        cmd.div_src    = DIV_OFF;
        cmd.res_src    = RES_ZERO;
        cmd.res_status = ST_OK;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req_type)
                    REQ_ALLOC:
                    begin
                        if (stat.head_valid)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_ALLOC_MUL;
                        end
                        else if (stat.mark_avail)
                        begin
                            cmd.take_mark = 1'b1;
                            state_next    = S_ALLOC_MUL;
                        end
                        else
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_LOAD;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (stat.is_null)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_NULL;
                            state_next     = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_FREE_MUL;
                        end
                    end
                    REQ_FREE_ALL:
                    begin
                        state_next = S_FA_MUL;
                    end
                    default:
                    begin
                        // unused request type answers ok
                        cmd.res_load = 1'b1;
                        state_next   = S_LOAD;
                    end
                endcase
            end
            S_ALLOC_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IDX;
                state_next  = S_ALLOC_ADD;
            end
            S_ALLOC_ADD:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_ALLOC;
                state_next   = S_LOAD;
            end
            S_FREE_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_TOTAL;
                cmd.off_load = 1'b1;
                state_next   = S_FREE_CMP;
            end
            S_FREE_CMP:
            begin
                if (stat.off_ge_region)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OOB;
                    state_next     = S_LOAD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_OFF;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_FA_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MAX;
                state_next  = S_FA_CMP;
            end
            S_FA_CMP:
            begin
                if (stat.len_ge_max)
                begin
                    // as many chunks as the list holds or more: saturate
                    cmd.total_max = 1'b1;
                    cmd.res_load  = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_LEN;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = (stat.req_type == REQ_FREE) ? S_FREE_END : S_FA_END;
                end
            end
            S_FREE_END:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_QUOT;
                if (stat.rem_nonzero)
                begin
                    cmd.res_status = ST_MISALIGNED;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                state_next = S_LOAD;
            end
            S_FA_END:
            begin
                cmd.total_quot = 1'b1;
                cmd.res_load   = 1'b1;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/fixed_chunk_pool_allocator_unit.sv =====
// top level of the fixed chunk pool allocator
//
//  channel  role   transaction
//  req      sink   alloc, free one chunk or free all
//  rsp      source status, chunk address and chunk number, one per request
//  cfg      sink   register write: 0 base, 1 length, 2 chunk size, 3 alignment
//
// one request in flight; an alloc passes the multiply and add; an empty pool, null free or
// unused type answers from dispatch; an out-of-bounds free or saturated free-all answers after
// the multiply and compare; other frees and free-all answer after the restoring divider
// a new request is taken while the previous response waits in the output register
// reset empties the free list and zeroes the chunk total; the link memory has no reset
// and needs no clearing pass; the geometry registers follow each register write
module fixed_chunk_pool_allocator_unit #(
    parameter int MAX_CHUNKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input logic         clk,
    input logic         rst_n,
    fcpa_req_if.sink    req,
    fcpa_rsp_if.source  rsp,
    fcpa_cfg_if.sink    cfg
);
    import fcpa_pkg::*;

    fcpa_cmd_t  cmd;
    fcpa_stat_t stat;

    // register writes always taken
    assign cfg.ready = 1'b1;

    fcpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fcpa_dpath #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .req_type     (req.req_type),
        .addr_is_null (req.addr_is_null),
        .free_addr    (req.free_addr),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .status       (rsp.status),
        .chunk_addr   (rsp.chunk_addr),
        .chunk_number (rsp.chunk_number),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench of the chunk pool allocator: directed plan, then random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcpa_pkg::*;

    localparam int                    POOL_DEPTH   = 1024;
    localparam logic [10:0]           NO_CHUNK     = 11'd1024;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED   = 2'd3;
    localparam int unsigned           HOLD_CYCLES  = 400;
    localparam int unsigned           CYCLE_LIMIT  = 400000;
    localparam int unsigned           RANDOM_ITEMS = 500;
    localparam logic [63:0]           MASK32       = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   kind;
        logic                    is_null;
        logic [FIELD_ADDR_W-1:0] addr;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] chunk_addr;
        logic [CNUM_W-1:0]       chunk_number;
    } pool_rsp_t;

    // one row of the directed plan: a register set or a request
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] csize;
        logic [CFG_DATA_W-1:0] align;
        pool_req_t             rq;
        logic                  typed;
        pool_rsp_t             want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    fcpa_req_if req_bus ();
    fcpa_rsp_if rsp_bus ();
    fcpa_cfg_if cfg_bus ();

    fixed_chunk_pool_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // shadow registers and free list state
    logic [31:0]        reg_base;
    logic [31:0]        reg_len;
    logic [CSIZE_W-1:0] reg_csize;
    logic [ALIGN_W-1:0] reg_align;
    logic [10:0]        head;
    logic [10:0]        mark;
    logic [10:0]        total;
    logic [10:0]        links [POOL_DEPTH];

    pool_rsp_t   pool_answers [$];
    logic [31:0] issued [$];
    plan_row_t   plan [$];

    int unsigned mismatches = 0;
    int unsigned random_items = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_rsp = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("fixed_chunk_pool_allocator_unit: mismatch");
        $finish;
    end

    // aligned base, cut length and rounded chunk size from raw register values
    function automatic void pool_geometry(input logic [31:0] b, input logic [31:0] l,
                                          input logic [CSIZE_W-1:0] cs,
                                          input logic [ALIGN_W-1:0] al,
                                          output longint unsigned g_base,
                                          output longint unsigned g_len,
                                          output longint unsigned g_size);
        longint unsigned a;
        longint unsigned adj;
        longint unsigned s;
        a = al;
        if (a == 0)
            a = 1;
        a = a & (~a + 1);
        adj = (a - (b & (a - 1))) & (a - 1);
        g_base = (b + adj) & MASK32;
        g_len = (l >= adj) ? l - adj : 0;
        s = cs;
        if (s == 0)
            s = 1;
        g_size = (s + a - 1) & ~(a - 1);
    endfunction

    // answer of the pool to one request, updating the free list
    function automatic pool_rsp_t pool_answer(pool_req_t rq);
        pool_rsp_t       res;
        longint unsigned gb;
        longint unsigned gl;
        longint unsigned gs;
        longint unsigned off;
        longint unsigned idx;
        logic [10:0]     pick;
        pool_geometry(reg_base, reg_len, reg_csize, reg_align, gb, gl, gs);
        res = '0;
        res.status = ST_OK;
        case (rq.kind)
            REQ_ALLOC:
            begin
                pick = NO_CHUNK;
                if (head < NO_CHUNK)
                begin
                    pick = head;
                    head = links[pick[9:0]];
                end
                else if (mark < total)
                begin
                    pick = mark;
                    mark = mark + 11'd1;
                end
                if (pick < NO_CHUNK)
                begin
                    res.chunk_addr = 32'((gb + pick * gs) & MASK32);
                    res.chunk_number = pick[9:0];
                end
                else
                    res.status = ST_EMPTY;
            end
            REQ_FREE:
            begin
                if (rq.is_null)
                    res.status = ST_NULL;
                else
                begin
                    off = (rq.addr - gb) & MASK32;
                    if (off >= total * gs)
                        res.status = ST_OOB;
                    else
                    begin
                        idx = off / gs;
                        res.chunk_number = 10'(idx);
                        if (off % gs != 0)
                            res.status = ST_MISALIGNED;
                        else
                        begin
                            links[10'(idx)] = head;
                            head = 11'(idx);
                        end
                    end
                end
            end
            REQ_FREE_ALL:
            begin
                idx = gl / gs;
                if (idx > POOL_DEPTH)
                    idx = POOL_DEPTH;
                total = 11'(idx);
                mark = 11'd0;
                head = NO_CHUNK;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic pool_req_t mk_req(logic [REQ_TYPE_W-1:0] kind, logic nul,
                                         logic [31:0] addr);
        pool_req_t r;
        r.kind = kind;
        r.is_null = nul;
        r.addr = addr;
        return r;
    endfunction

    function automatic void add_req(logic [REQ_TYPE_W-1:0] kind, logic nul, logic [31:0] addr);
        plan_row_t row;
        row = '0;
        row.rq = mk_req(kind, nul, addr);
        plan.push_back(row);
    endfunction

    function automatic void add_typed(logic [REQ_TYPE_W-1:0] kind, logic nul, logic [31:0] addr,
                                      logic [STATUS_W-1:0] st, logic [31:0] caddr,
                                      logic [CNUM_W-1:0] cnum);
        plan_row_t row;
        row = '0;
        row.rq = mk_req(kind, nul, addr);
        row.typed = 1'b1;
        row.want.status = st;
        row.want.chunk_addr = caddr;
        row.want.chunk_number = cnum;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [31:0] b, logic [31:0] l, logic [31:0] cs,
                                    logic [31:0] al);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.base = b;
        row.len = l;
        row.csize = cs;
        row.align = al;
        plan.push_back(row);
    endfunction

    // one request transaction, expectation queued at acceptance
    task automatic issue(pool_req_t rq, logic typed, pool_rsp_t want);
        int unsigned gap;
        pool_rsp_t   predicted;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= rq.kind;
        req_bus.addr_is_null <= rq.is_null;
        req_bus.free_addr <= rq.addr;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        predicted = pool_answer(rq);
        if (rq.kind == REQ_FREE_ALL)
            issued.delete();
        else if (rq.kind == REQ_ALLOC && predicted.status == ST_OK)
            issued.push_back(predicted.chunk_addr);
        pool_answers.push_back(typed ? want : predicted);
    endtask

    // one register write transaction; valid is left high for a following write
    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_BUFFER_BASE:     reg_base = val;
            CFG_BUFFER_LENGTH:   reg_len = val;
            CFG_CHUNK_SIZE:      reg_csize = val[CSIZE_W-1:0];
            CFG_CHUNK_ALIGNMENT: reg_align = val[ALIGN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_geometry(logic [31:0] b, logic [31:0] l, logic [31:0] cs,
                                  logic [31:0] al);
        cfg_put(CFG_BUFFER_BASE, b);
        cfg_put(CFG_BUFFER_LENGTH, l);
        cfg_put(CFG_CHUNK_SIZE, cs);
        cfg_put(CFG_CHUNK_ALIGNMENT, al);
        cfg_bus.valid <= 1'b0;
        // let the new geometry pass the datapath geometry registers
        repeat (4) @(posedge clk);
    endtask

    // wait until every queued answer has come back
    task automatic settle_pool();
        req_bus.valid <= 1'b0;
        while (pool_answers.size() != 0)
            @(posedge clk);
    endtask

    // one random phase: fresh geometry, then mostly alloc/free traffic
    task automatic run_phase(bit squeeze);
        logic [31:0]        b;
        logic [31:0]        l;
        logic [CSIZE_W-1:0] cs;
        logic [ALIGN_W-1:0] al;
        longint unsigned    gb;
        longint unsigned    gl;
        longint unsigned    gs;
        longint unsigned    adj;
        int unsigned        n;
        int unsigned        k;
        int unsigned        roll;
        int unsigned        pick;
        pool_req_t          rq;

        // draw geometry, mostly small pools with power-of-two alignment
        al = 13'(1) << $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0)
            al = 13'($urandom_range(0, 8191));
        case ($urandom_range(0, 9))
            0: cs = 16'($urandom_range(0, 65535));
            1: cs = 16'd0;
            default: cs = 16'($urandom_range(1, 64));
        endcase
        b = $urandom;
        pool_geometry(b, 32'd0, cs, al, gb, gl, gs);
        adj = (gb - b) & MASK32;
        case ($urandom_range(0, 9))
            0: l = $urandom;
            1: l = 32'($urandom_range(0, int'(adj)));
            default: l = 32'(adj + $urandom_range(1, 40) * gs + $urandom_range(0, int'(gs - 1)));
        endcase

        settle_pool();
        write_geometry(b, l,
                       {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0, cs},
                       {($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'd0, al});

        tx_burst = squeeze || ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        if (squeeze)
            hold_rsp = 1'b1;

        if ($urandom_range(0, 9) != 0)
            issue(mk_req(REQ_FREE_ALL, 1'($urandom), $urandom), 1'b0, '0);

        n = squeeze ? 60 : $urandom_range(20, 60);
        for (k = 0; k < n; k++)
        begin
            pool_geometry(reg_base, reg_len, reg_csize, reg_align, gb, gl, gs);
            roll = $urandom_range(0, 99);
            rq = mk_req(REQ_FREE, 1'b0, $urandom);
            if (roll < 45)
                rq.kind = REQ_ALLOC;
            else if (roll < 75)
            begin
                // free a chunk handed out earlier, or any chunk boundary
                if (issued.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    pick = $urandom_range(0, issued.size() - 1);
                    rq.addr = issued[pick];
                    issued.delete(pick);
                end
                else if (total != 0)
                    rq.addr = 32'(gb + $urandom_range(0, total - 1) * gs);
            end
            else if (roll < 82)
                rq.addr = 32'(gb + $urandom_range(0, total) * gs
                              + $urandom_range(1, (gs > 1) ? int'(gs - 1) : 1));
            else if (roll < 87)
            begin
                // past the last whole chunk, or just below the base
                if ($urandom_range(0, 1) == 1)
                    rq.addr = 32'(gb + total * gs + $urandom_range(0, int'(3 * gs)));
                else
                    rq.addr = 32'(gb - $urandom_range(1, 4096));
            end
            else if (roll < 91)
                rq.is_null = 1'b1;
            else if (roll < 94)
                rq.kind = REQ_FREE_ALL;
            else if (roll < 96)
                rq.kind = REQ_UNUSED;
            else
            begin
                rq.kind = 2'($urandom);
                rq.is_null = 1'($urandom);
            end
            issue(rq, 1'b0, '0);
            if (rq.kind != REQ_UNUSED)
                random_items++;
        end
    endtask

    // response side: random stalls, one long hold-off, and the result check
    initial
    begin : rsp_side
        int unsigned stall;
        pool_rsp_t   want;
        stall = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                if (pool_answers.size() == 0)
                begin
                    $display("%0t: unexpected transaction: status %0d addr %h number %0d",
                             $time, rsp_bus.status, rsp_bus.chunk_addr, rsp_bus.chunk_number);
                    mismatches++;
                end
                else
                begin
                    want = pool_answers.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_bus.status);
                        mismatches++;
                    end
                    if (rsp_bus.chunk_addr !== want.chunk_addr)
                    begin
                        $display("%0t: chunk_addr expected %h actual %h",
                                 $time, want.chunk_addr, rsp_bus.chunk_addr);
                        mismatches++;
                    end
                    if (rsp_bus.chunk_number !== want.chunk_number)
                    begin
                        $display("%0t: chunk_number expected %0d actual %0d",
                                 $time, want.chunk_number, rsp_bus.chunk_number);
                        mismatches++;
                    end
                end
                stall = rx_burst ? 0 : $urandom_range(0, 17);
            end
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // reset, directed plan, random phases, end of run
    initial
    begin : stimulus
        int unsigned i;
        int unsigned phase;
        plan_row_t   row;

        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= REQ_ALLOC;
        req_bus.addr_is_null <= 1'b0;
        req_bus.free_addr <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_BUFFER_BASE;
        cfg_bus.data <= '0;

        reg_base = '0;
        reg_len = '0;
        reg_csize = CHUNK_SIZE_RST;
        reg_align = CHUNK_ALIGN_RST;
        head = NO_CHUNK;
        mark = 11'd0;
        total = 11'd0;

        // reset geometry: no chunks at all
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_EMPTY, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h0, ST_OOB, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b1, 32'hFFFF_FFFF, ST_NULL, 32'h0, 10'd0);
        add_typed(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_FREE_ALL, 1'b0, 32'h0, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_EMPTY, 32'h0, 10'd0);
        // unaligned base: 15 chunks of 16 bytes from 0x1008, tail slack after them
        add_cfg(32'h0000_1003, 32'h0000_0100, 32'd10, 32'd8);
        add_typed(REQ_FREE_ALL, 1'b0, 32'h0, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_OK, 32'h0000_1008, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h0000_1008, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h0000_100C, ST_MISALIGNED, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h0000_10F8, ST_OOB, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h0000_1007, ST_OOB, 32'h0, 10'd0);
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_OK, 32'h0000_1008, 10'd0);
        // largest everything: base wraps to 0, 64 KiB chunks, count saturates
        add_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd4096);
        add_typed(REQ_FREE_ALL, 1'b0, 32'h0, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_OK, 32'h0, 10'd0);
        add_typed(REQ_FREE, 1'b0, 32'h03FF_0000, ST_OK, 32'h0, 10'd1023);
        add_typed(REQ_ALLOC, 1'b0, 32'h0, ST_OK, 32'h03FF_0000, 10'd1023);
        add_typed(REQ_FREE, 1'b0, 32'h0400_0000, ST_OOB, 32'h0, 10'd0);
        // short buffer with a non power-of-two alignment and zero chunk size
        add_cfg(32'h0000_0005, 32'h0000_0002, 32'd0, 32'd12);
        add_req(REQ_FREE_ALL, 1'b0, 32'h0);
        add_req(REQ_ALLOC, 1'b0, 32'h0);
        // zero alignment, byte chunks wrapping past the top of the address space
        add_cfg(32'hFFFF_FFFE, 32'h0000_0004, 32'd0, 32'd0);
        add_req(REQ_FREE_ALL, 1'b0, 32'h0);
        add_req(REQ_ALLOC, 1'b0, 32'h0);
        add_req(REQ_ALLOC, 1'b0, 32'h0);
        add_req(REQ_FREE, 1'b0, 32'h0000_0001);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (i = 0; i < plan.size(); i++)
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                settle_pool();
                write_geometry(row.base, row.len, row.csize, row.align);
            end
            else
                issue(row.rq, row.typed, row.want);
        end

        // random phases, the second one with a long response hold-off
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            run_phase(phase == 1);
            phase++;
        end

        settle_pool();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pool_answers.size() == 0)
            $display("fixed_chunk_pool_allocator_unit: match");
        else
            $display("fixed_chunk_pool_allocator_unit: mismatch");
        $finish;
    end

endmodule
